FILE: hw/rtl/clt_pkg.sv
package clt_pkg;

	localparam int MAX_CLIPS = 16;
	localparam int MAX_ANIMATIONS = 16;
	localparam int LEN_W = 24;
	localparam int TOT_W = 28;
	localparam int DVD_W = 40;
	localparam int DVS_W = 32;
	localparam int FRAC_W = 16;

	localparam logic [1:0] MODE_CLIP = 2'd0;
	localparam logic [1:0] MODE_ANIM = 2'd1;
	localparam logic [1:0] MODE_EVAL = 2'd2;

	localparam logic [1:0] CFG_LOOP = 2'd0;
	localparam logic [1:0] CFG_CLIPS = 2'd1;
	localparam logic [1:0] CFG_ANIMS = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [3:0]       slot;
		logic [3:0]       clip_animation;
		logic [LEN_W-1:0] clip_length;
		logic             clip_repeats;
		logic [LEN_W-1:0] clip_fade_length;
		logic [LEN_W-1:0] animation_length;
		logic [31:0]      query_time;
	} cmd_t;

	typedef struct packed {
		logic              valid_res;
		logic [3:0]        active_animation;
		logic [LEN_W-1:0]  local_ticks;
		logic              blending;
		logic [FRAC_W-1:0] blend_fraction;
		logic [3:0]        next_animation;
		logic [LEN_W-1:0]  next_local_ticks;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} div_rsp_t;

endpackage

FILE: hw/rtl/clt_div.sv
module clt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  clt_pkg::div_req_t req,
	output clt_pkg::div_rsp_t rsp
);
	import clt_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] num_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] den_q;
	logic [DVS_W:0]   sh;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign sh = {rem_q, num_q[DVD_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[DVS_W-1:0];
				num_q <= {num_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[DVS_W-1:0];
				num_q <= {num_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = num_q;
	assign rsp.remainder = rem_q;

endmodule

FILE: hw/rtl/clip_timeline_locator_top.sv
// Channel | Direction | Handshake          | Payload
// cmd     | in        | cmd_valid/stall    | cmd (clt_pkg::cmd_t)
// res     | out       | res_valid/stall    | res (clt_pkg::res_t)
// cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
// A table write gives no result.
// An evaluation item walks the N clips in use and makes up to three passes of the
// shared bit-serial divider: one for the sequence wrap when looping, one for a
// repeating clip and one for the blend fraction.
// Reset clears the tables, configuration and control state; the result register
// parts the sides; a held result waits for res_stall to fall before the next loads.
module clip_timeline_locator_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  clt_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output clt_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [4:0]    cfg_data
);
	import clt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SUM, S_WRAP, S_DIVT, S_WALK, S_DIVL, S_BLEND, S_DIVB, S_END, S_PUSH
	} state_t;

	state_t state_q;

	logic             loop_q;
	logic [4:0]       clips_q;
	logic [4:0]       anims_q;
	logic [3:0]       clip_anim_q [MAX_CLIPS];
	logic [LEN_W-1:0] clip_len_q [MAX_CLIPS];
	logic             clip_rep_q [MAX_CLIPS];
	logic [LEN_W-1:0] clip_fade_q [MAX_CLIPS];
	logic [LEN_W-1:0] anim_len_q [MAX_ANIMATIONS];

	logic [4:0]       ci_q;
	logic [31:0]      t_q;
	logic [TOT_W-1:0] total_q;
	logic [LEN_W-1:0] fade_q;
	logic [LEN_W-1:0] remain_q;
	logic [LEN_W-1:0] win_q;
	logic             has_next_q;
	res_t             acc_q;
	res_t             res_q;
	logic             res_valid_q;
	div_req_t         div_req_q;
	div_rsp_t         div_rsp;

	logic [4:0]       nc;
	logic [4:0]       na;
	logic [3:0]       idx;
	logic [3:0]       anim_idx;
	logic [LEN_W-1:0] alen;
	logic [LEN_W-1:0] dur;
	logic             cmd_acc;
	logic             res_acc;

	assign nc = (clips_q > 5'(MAX_CLIPS)) ? 5'(MAX_CLIPS) : clips_q;
	assign na = (anims_q > 5'(MAX_ANIMATIONS)) ? 5'(MAX_ANIMATIONS) : anims_q;
	assign idx = ci_q[3:0];
	assign anim_idx = ({1'b0, clip_anim_q[idx]} > na - 5'd1) ? 4'(na - 5'd1)
		: clip_anim_q[idx];
	assign alen = anim_len_q[anim_idx];
	assign dur = (clip_len_q[idx] != '0) ? clip_len_q[idx] : alen;

	assign cmd_stall = state_q != S_IDLE;
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign res_acc = res_valid_q && !res_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	clt_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req_q),
		.rsp(div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
			clips_q <= '0;
			anims_q <= '0;
			for (int i = 0; i < MAX_CLIPS; i++) begin
				clip_anim_q[i] <= '0;
				clip_len_q[i] <= '0;
				clip_rep_q[i] <= 1'b0;
				clip_fade_q[i] <= '0;
			end
			for (int i = 0; i < MAX_ANIMATIONS; i++) begin
				anim_len_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LOOP:  loop_q <= cfg_data[0];
					CFG_CLIPS: clips_q <= cfg_data;
					CFG_ANIMS: anims_q <= cfg_data;
					default:   ;
				endcase
			end
			if (cmd_acc && cmd.mode == MODE_CLIP) begin
				clip_anim_q[cmd.slot] <= cmd.clip_animation;
				clip_len_q[cmd.slot] <= cmd.clip_length;
				clip_rep_q[cmd.slot] <= cmd.clip_repeats;
				clip_fade_q[cmd.slot] <= cmd.clip_fade_length;
			end
			if (cmd_acc && cmd.mode == MODE_ANIM) begin
				anim_len_q[cmd.slot] <= cmd.animation_length;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (res_acc) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc && cmd.mode == MODE_EVAL) begin
						t_q <= cmd.query_time;
						ci_q <= '0;
						total_q <= '0;
						acc_q <= '0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (nc == '0 || na == '0) begin
						state_q <= S_PUSH;
					end else begin
						total_q <= total_q + TOT_W'(dur);
						if (ci_q == nc - 5'd1) begin
							state_q <= S_WRAP;
						end else begin
							ci_q <= ci_q + 5'd1;
						end
					end
				end
				S_WRAP: begin
					ci_q <= '0;
					if (total_q == '0) begin
						state_q <= S_PUSH;
					end else begin
						acc_q.valid_res <= 1'b1;
						if (loop_q) begin
							div_req_q.start <= 1'b1;
							div_req_q.dividend <= DVD_W'(t_q);
							div_req_q.divisor <= DVS_W'(total_q);
							state_q <= S_DIVT;
						end else begin
							if (t_q > 32'(total_q)) begin
								t_q <= 32'(total_q);
							end
							state_q <= S_WALK;
						end
					end
				end
				S_DIVT: begin
					if (div_rsp.done) begin
						t_q <= div_rsp.remainder;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (t_q >= 32'(dur)) begin
						t_q <= t_q - 32'(dur);
						if (ci_q == nc - 5'd1) begin
							state_q <= S_END;
						end else begin
							ci_q <= ci_q + 5'd1;
						end
					end else begin
						acc_q.active_animation <= anim_idx;
						fade_q <= clip_fade_q[idx];
						remain_q <= dur - t_q[LEN_W-1:0];
						has_next_q <= loop_q || (ci_q + 5'd1 < nc);
						if (alen == '0) begin
							acc_q.local_ticks <= '0;
							state_q <= S_BLEND;
						end else if (clip_rep_q[idx]) begin
							div_req_q.start <= 1'b1;
							div_req_q.dividend <= DVD_W'(t_q[LEN_W-1:0]);
							div_req_q.divisor <= DVS_W'(alen);
							state_q <= S_DIVL;
						end else begin
							acc_q.local_ticks <= (t_q[LEN_W-1:0] < alen - 1'b1)
								? t_q[LEN_W-1:0] : alen - 1'b1;
							state_q <= S_BLEND;
						end
					end
				end
				S_DIVL: begin
					if (div_rsp.done) begin
						acc_q.local_ticks <= div_rsp.remainder[LEN_W-1:0];
						state_q <= S_BLEND;
					end
				end
				S_BLEND: begin
					if (fade_q != '0 && has_next_q && remain_q <= fade_q) begin
						win_q <= fade_q - remain_q;
						ci_q <= (ci_q + 5'd1 == nc) ? 5'd0 : ci_q + 5'd1;
						div_req_q.start <= 1'b1;
						div_req_q.dividend <= {(fade_q - remain_q), FRAC_W'(0)};
						div_req_q.divisor <= DVS_W'(fade_q);
						state_q <= S_DIVB;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_DIVB: begin
					if (div_rsp.done) begin
						acc_q.blending <= 1'b1;
						acc_q.blend_fraction <= div_rsp.quotient[FRAC_W-1:0];
						acc_q.next_animation <= anim_idx;
						acc_q.next_local_ticks <= win_q;
						state_q <= S_PUSH;
					end
				end
				S_END: begin
					acc_q.active_animation <= anim_idx;
					acc_q.local_ticks <= (alen == '0) ? '0 : alen - 1'b1;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!res_valid_q || !res_stall) begin
						res_q <= acc_q;
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_push_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == S_PUSH)
		else $error("result appeared without the sequencer finishing");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIVT || state_q == S_DIVL || state_q == S_DIVB))
		else $error("divider finished while the sequencer was not waiting");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.valid_res) |-> (res.local_ticks == '0 && !res.blending))
		else $error("invalid result carries non-zero fields");

endmodule
